// File: rtl/assert_macros.svh
// assertion macros used by the tag array back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define AST_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AST_IMPL(label, clk, rst, a, c)
`define AST_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/sat_pkg.sv
// shared types and constants of the tag array
`timescale 1ns / 1ps
package sat_pkg;
  localparam int DEF_MAX_WAYS  = 8;
  localparam int DEF_MAX_SETS  = 512;
  localparam int DEF_LINE_BITS = 32;

  localparam int OP_W     = 2;
  localparam int LINE_W   = 32;
  localparam int SET_W    = 9;
  localparam int SLOT_W   = 12;
  localparam int STAT_W   = 2;
  localparam int WAYS_W   = 4;
  localparam int SETS_W   = 10;
  localparam int CNT_W    = 14;
  localparam int CIDX_W   = 2;
  localparam int QDEPTH   = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_INVAL  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_SET_ERR = 2'd1;
  localparam logic [STAT_W-1:0] ST_SLOT_ERR = 2'd2;

  localparam logic [CIDX_W-1:0] REG_WAYS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SETS = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LINE_W-1:0] line;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  slot;
    logic [WAYS_W-1:0] ways;
  } cmd_t;
endpackage

// File: rtl/sat_front.sv
// front end: configuration registers and command classification
`timescale 1ns / 1ps
module sat_front #(
  parameter int MAX_WAYS = sat_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS = sat_pkg::DEF_MAX_SETS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [sat_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sat_pkg::SETS_W-1:0]  cfg_data,
  input  logic [sat_pkg::OP_W-1:0]    op,
  input  logic [sat_pkg::LINE_W-1:0]  line_id,
  input  logic [sat_pkg::SET_W-1:0]   set_number,
  input  logic [sat_pkg::SLOT_W-1:0]  slot_number,
  output sat_pkg::cmd_t               cmd
);
  import sat_pkg::*;

  logic [WAYS_W-1:0] ways_reg;
  logic [SETS_W-1:0] sets_reg;
  logic [WAYS_W-1:0] ways_e;
  logic [SETS_W-1:0] sets_e;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  base;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_reg <= WAYS_W'(8);
      sets_reg <= SETS_W'(512);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WAYS) ways_reg <= cfg_data[WAYS_W-1:0];
      else if (cfg_index == REG_SETS) sets_reg <= cfg_data;
    end
  end

  always_comb begin
    if (ways_reg == '0) ways_e = WAYS_W'(1);
    else if (int'(ways_reg) > MAX_WAYS) ways_e = WAYS_W'(MAX_WAYS);
    else ways_e = ways_reg;
    if (sets_reg == '0) sets_e = SETS_W'(1);
    else if (int'(sets_reg) > MAX_SETS) sets_e = SETS_W'(MAX_SETS);
    else sets_e = sets_reg;
    total = CNT_W'(ways_e) * CNT_W'(sets_e);
    base  = CNT_W'(set_number) * CNT_W'(ways_e);

    cmd.op   = op;
    cmd.line = line_id;
    cmd.ways = ways_e;
    if (op == OP_LOOKUP || op == OP_LIST) begin
      cmd.slot   = base;
      cmd.status = (SETS_W'(set_number) >= sets_e) ? ST_SET_ERR : ST_OK;
    end else begin
      cmd.slot   = CNT_W'(slot_number);
      cmd.status = (CNT_W'(slot_number) >= total) ? ST_SLOT_ERR : ST_OK;
    end
  end
endmodule

// File: rtl/sat_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
module sat_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sat_pkg::cmd_t push_cmd,
  input  logic          pop,
  output sat_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import sat_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t            q [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == PW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

// File: rtl/sat_back.sv
// back end: slot memory, clearing pass and per-way execution
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sat_back #(
  parameter int MAX_WAYS  = sat_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS  = sat_pkg::DEF_MAX_SETS,
  parameter int LINE_BITS = sat_pkg::DEF_LINE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  sat_pkg::cmd_t               head,
  output logic                        pop,
  output logic                        clearing,
  output logic                        result_valid,
  output logic [sat_pkg::STAT_W-1:0]  status,
  output logic                        hit,
  output logic [sat_pkg::SLOT_W-1:0]  hit_slot,
  output logic                        free_found,
  output logic [sat_pkg::SLOT_W-1:0]  lowest_free,
  output logic [sat_pkg::SLOT_W-1:0]  entry_slot,
  output logic                        entry_valid,
  output logic [sat_pkg::LINE_W-1:0]  entry_line,
  output logic                        last
);
  import sat_pkg::*;

  localparam int DEPTH = MAX_WAYS * MAX_SETS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;

  logic [LINE_BITS:0]   mem [DEPTH];
  logic [LINE_BITS:0]   rd_q;
  logic [AW-1:0]        clr_addr;
  logic [1:0]           st;
  cmd_t                 cur;
  logic [WAYS_W-1:0]    way;
  logic [CNT_W-1:0]     slot_c;
  logic                 hit_f, fr_f;
  logic [CNT_W-1:0]     hit_s, fr_s;
  logic                 hit_n, fr_n;
  logic [CNT_W-1:0]     hit_sn, fr_sn;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [LINE_BITS:0]   wdata;
  logic                 rd_v;
  logic [LINE_BITS-1:0] rd_l;
  logic                 last_way;

  assign pop      = (st == S_IDLE) && !clearing && !empty;
  assign rd_v     = rd_q[LINE_BITS];
  assign rd_l     = rd_q[LINE_BITS-1:0];
  assign last_way = (way == cur.ways - 1'b1);

  // way compare, first match and lowest free slot
  always_comb begin
    hit_n = hit_f;
    hit_sn = hit_s;
    fr_n = fr_f;
    fr_sn = fr_s;
    if (rd_v) begin
      if (!hit_f && rd_l == LINE_BITS'(cur.line)) begin
        hit_n = 1'b1;
        hit_sn = slot_c;
      end
    end else if (!fr_f) begin
      fr_n = 1'b1;
      fr_sn = slot_c;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(slot_c);
    wdata = '0;
    if (clearing) begin
      we = 1'b1;
      waddr = clr_addr;
    end else if (st == S_EV && cur.op == OP_INSERT) begin
      we = 1'b1;
      wdata = {1'b1, LINE_BITS'(cur.line)};
    end else if (pop && head.op == OP_INVAL && head.status == ST_OK) begin
      we = 1'b1;
      waddr = AW'(head.slot);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[AW'(slot_c)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH-1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            way <= '0;
            slot_c <= head.slot;
            hit_f <= 1'b0;
            fr_f <= 1'b0;
            hit_s <= '0;
            fr_s <= '0;
            if (head.status != ST_OK || head.op == OP_INVAL) begin
              result_valid <= 1'b1;
              status <= head.status;
              hit <= 1'b0;
              hit_slot <= '0;
              free_found <= 1'b0;
              lowest_free <= '0;
              entry_slot <= '0;
              entry_valid <= 1'b0;
              entry_line <= '0;
              last <= 1'b1;
            end else begin
              st <= S_RD;
            end
          end
        end
        S_RD: st <= S_EV;
        S_EV: begin
          status <= ST_OK;
          hit <= 1'b0;
          hit_slot <= '0;
          free_found <= 1'b0;
          lowest_free <= '0;
          entry_slot <= '0;
          entry_valid <= 1'b0;
          entry_line <= '0;
          last <= 1'b1;
          hit_f <= hit_n;
          hit_s <= hit_sn;
          fr_f <= fr_n;
          fr_s <= fr_sn;
          case (cur.op)
            OP_LOOKUP: begin
              if (last_way) begin
                result_valid <= 1'b1;
                hit <= hit_n;
                hit_slot <= hit_n ? SLOT_W'(hit_sn) : '0;
                free_found <= fr_n;
                lowest_free <= fr_n ? SLOT_W'(fr_sn) : '0;
              end
            end
            OP_LIST: begin
              result_valid <= 1'b1;
              entry_slot <= SLOT_W'(slot_c);
              entry_valid <= rd_v;
              entry_line <= rd_v ? LINE_W'(rd_l) : '0;
              last <= last_way;
            end
            default: begin
              // insert reports the replaced line
              result_valid <= 1'b1;
              entry_valid <= rd_v;
              entry_line <= rd_v ? LINE_W'(rd_l) : '0;
            end
          endcase
          if (last_way || cur.op == OP_INSERT) begin
            st <= S_IDLE;
          end else begin
            way <= way + 1'b1;
            slot_c <= slot_c + 1'b1;
            st <= S_RD;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `AST_IMPL(a_busy_no_clear, clk, rst, st != S_IDLE, !clearing)
  `AST_IMPL(a_way_range, clk, rst, st != S_IDLE, way < cur.ways)
  `AST_NEXT(a_insert_done, clk, rst, st == S_EV && cur.op == OP_INSERT, result_valid && last)
  `AST_IMPL(a_no_res_clear, clk, rst, clearing, !result_valid)
endmodule

// File: rtl/set_associative_tag_array.sv
// an error or invalidate result is registered when the back end pops the command;
// lookup and list read the ways of the set one at a time through the single read
// port of the slot memory, and insert reads its one slot; a list delivers one
// result per way; results cannot stall; commands queue two deep; busy rises when
// the queue is full; reset: synchronous; a clearing pass frees all MAX_WAYS*MAX_SETS
// slots while busy is high; configuration writes are taken during it
`timescale 1ns / 1ps
module set_associative_tag_array #(
  parameter int MAX_WAYS  = sat_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS  = sat_pkg::DEF_MAX_SETS,
  parameter int LINE_BITS = sat_pkg::DEF_LINE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sat_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sat_pkg::SETS_W-1:0]  cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [sat_pkg::OP_W-1:0]    op,
  input  logic [sat_pkg::LINE_W-1:0]  line_id,
  input  logic [sat_pkg::SET_W-1:0]   set_number,
  input  logic [sat_pkg::SLOT_W-1:0]  slot_number,
  output logic                        result_valid,
  output logic [sat_pkg::STAT_W-1:0]  status,
  output logic                        hit,
  output logic [sat_pkg::SLOT_W-1:0]  hit_slot,
  output logic                        free_found,
  output logic [sat_pkg::SLOT_W-1:0]  lowest_free,
  output logic [sat_pkg::SLOT_W-1:0]  entry_slot,
  output logic                        entry_valid,
  output logic [sat_pkg::LINE_W-1:0]  entry_line,
  output logic                        last
);
  import sat_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic full, empty, pop, clearing, push;

  assign cfg_ready = 1'b1;
  assign busy = clearing || full;
  assign push = start && !busy;

  sat_front #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_front (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .op(op), .line_id(line_id), .set_number(set_number),
    .slot_number(slot_number), .cmd(cmd)
  );

  sat_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(cmd), .pop(pop),
    .head(head), .full(full), .empty(empty)
  );

  sat_back #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS), .LINE_BITS(LINE_BITS)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop), .clearing(clearing),
    .result_valid(result_valid), .status(status), .hit(hit), .hit_slot(hit_slot),
    .free_found(free_found), .lowest_free(lowest_free), .entry_slot(entry_slot),
    .entry_valid(entry_valid), .entry_line(entry_line), .last(last)
  );
endmodule

// File: dv/set_associative_tag_array_checker.sv
// checker that predicts and compares the results of the tag array
`timescale 1ns / 1ps
module set_associative_tag_array_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [sat_pkg::CIDX_W-1:0] cfg_index,
  input  logic [sat_pkg::SETS_W-1:0] cfg_data,
  input  logic                       start,
  input  logic                       busy,
  input  logic [sat_pkg::OP_W-1:0]   op,
  input  logic [sat_pkg::LINE_W-1:0] line_id,
  input  logic [sat_pkg::SET_W-1:0]  set_number,
  input  logic [sat_pkg::SLOT_W-1:0] slot_number,
  input  logic                       result_valid,
  input  logic [sat_pkg::STAT_W-1:0] status,
  input  logic                       hit,
  input  logic [sat_pkg::SLOT_W-1:0] hit_slot,
  input  logic                       free_found,
  input  logic [sat_pkg::SLOT_W-1:0] lowest_free,
  input  logic [sat_pkg::SLOT_W-1:0] entry_slot,
  input  logic                       entry_valid,
  input  logic [sat_pkg::LINE_W-1:0] entry_line,
  input  logic                       last,
  output int                         fail_count,
  output int                         pending
);
  import sat_pkg::*;

  localparam int DEPTH = DEF_MAX_WAYS * DEF_MAX_SETS;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_found;
    logic [SLOT_W-1:0] lowest_free;
    logic [SLOT_W-1:0] entry_slot;
    logic              entry_valid;
    logic [LINE_W-1:0] entry_line;
    logic              last;
  } tag_result_t;

  logic [LINE_W-1:0] line_store [DEPTH];
  logic              valid_store [DEPTH];
  logic [WAYS_W-1:0] ways_reg;
  logic [SETS_W-1:0] sets_reg;
  tag_result_t       expected_results [$];

  function automatic tag_result_t blank_result(logic [STAT_W-1:0] st);
    tag_result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic queue_result(tag_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_command(logic [OP_W-1:0] c_op, logic [LINE_W-1:0] c_line,
                                 int c_set, int c_slot);
    int ways, sets, base, s;
    tag_result_t r;
    ways = (ways_reg == 0) ? 1 : (ways_reg > DEF_MAX_WAYS ? DEF_MAX_WAYS : ways_reg);
    sets = (sets_reg == 0) ? 1 : (sets_reg > DEF_MAX_SETS ? DEF_MAX_SETS : sets_reg);
    base = c_set * ways;
    if (c_op == OP_LOOKUP || c_op == OP_LIST) begin
      if (c_set >= sets) begin
        queue_result(blank_result(ST_SET_ERR));
      end else if (c_op == OP_LOOKUP) begin
        r = blank_result(ST_OK);
        for (int w = 0; w < ways; w++) begin
          s = base + w;
          if (valid_store[s]) begin
            if (!r.hit && line_store[s] == c_line) begin
              r.hit = 1'b1;
              r.hit_slot = SLOT_W'(s);
            end
          end else if (!r.free_found) begin
            r.free_found = 1'b1;
            r.lowest_free = SLOT_W'(s);
          end
        end
        queue_result(r);
      end else begin
        for (int w = 0; w < ways; w++) begin
          s = base + w;
          r = '0;
          r.entry_slot = SLOT_W'(s);
          r.entry_valid = valid_store[s];
          r.entry_line = valid_store[s] ? line_store[s] : '0;
          r.last = (w == ways - 1);
          queue_result(r);
        end
      end
    end else if (c_slot >= ways * sets) begin
      queue_result(blank_result(ST_SLOT_ERR));
    end else begin
      r = blank_result(ST_OK);
      if (c_op == OP_INSERT) begin
        r.entry_valid = valid_store[c_slot];
        r.entry_line = valid_store[c_slot] ? line_store[c_slot] : '0;
        line_store[c_slot] = c_line;
        valid_store[c_slot] = 1'b1;
      end else begin
        valid_store[c_slot] = 1'b0;
      end
      queue_result(r);
    end
  endtask

  always @(posedge clk) begin
    tag_result_t got, want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) valid_store[i] = 1'b0;
      ways_reg = WAYS_W'(DEF_MAX_WAYS);
      sets_reg = SETS_W'(DEF_MAX_SETS);
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAYS: ways_reg = cfg_data[WAYS_W-1:0];
          REG_SETS: sets_reg = cfg_data;
          default: ;
        endcase
      end
      if (result_valid) begin
        got = '{status, hit, hit_slot, free_found, lowest_free, entry_slot,
                entry_valid, entry_line, last};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected: %p", want);
              $display("  actual:   %p", got);
            end
          end
        end
      end
      if (start && !busy)
        predict_command(op, line_id, set_number, slot_number);
    end
    pending = expected_results.size();
  end
endmodule

// File: dv/tb_set_associative_tag_array.sv
// top of the tag array testbench: stimulus, configuration and verdict
`timescale 1ns / 1ps
module tb_set_associative_tag_array;
  import sat_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [SETS_W-1:0] cfg_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   op = OP_LOOKUP;
  logic [LINE_W-1:0] line_id = '0;
  logic [SET_W-1:0]  set_number = '0;
  logic [SLOT_W-1:0] slot_number = '0;
  logic              result_valid;
  logic [STAT_W-1:0] status;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] lowest_free;
  logic [SLOT_W-1:0] entry_slot;
  logic              entry_valid;
  logic [LINE_W-1:0] entry_line;
  logic              last;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                idle_pct = 0;
  int                eff_ways = DEF_MAX_WAYS;
  int                eff_sets = DEF_MAX_SETS;
  logic [LINE_W-1:0] line_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_associative_tag_array u_top (.*);

  set_associative_tag_array_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // all tasks start and end at a falling edge
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [SETS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(int ways, int sets);
    write_reg(REG_WAYS, SETS_W'(ways));
    write_reg(REG_SETS, SETS_W'(sets));
    @(negedge clk);
    eff_ways = (ways == 0) ? 1 : (ways > DEF_MAX_WAYS ? DEF_MAX_WAYS : ways);
    eff_sets = (sets == 0) ? 1 : (sets > DEF_MAX_SETS ? DEF_MAX_SETS : sets);
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // busy only moves at rising edges, so a low busy here holds at the next one
  task automatic issue(logic [OP_W-1:0] c_op, logic [LINE_W-1:0] c_line,
                       int c_set, int c_slot);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    op <= c_op;
    line_id <= c_line;
    set_number <= SET_W'(c_set);
    slot_number <= SLOT_W'(c_slot);
    @(negedge clk);
  endtask

  task automatic random_command;
    logic [OP_W-1:0]   c_op;
    logic [LINE_W-1:0] c_line;
    int                c_set, c_slot;
    c_op = OP_W'($urandom_range(0, 3));
    c_line = ($urandom_range(0, 9) < 7) ? line_pool[$urandom_range(0, 7)] : $urandom;
    if ($urandom_range(0, 9) == 0) begin
      // noise: full field range, often out of the configured geometry
      c_set = $urandom_range(0, 511);
      c_slot = $urandom_range(0, 4095);
    end else begin
      c_set = $urandom_range(0, eff_sets - 1);
      // keep traffic near the looked-up set so hits and full sets occur
      c_slot = ($urandom_range(0, 1) == 1)
               ? c_set * eff_ways + $urandom_range(0, eff_ways - 1)
               : $urandom_range(0, eff_ways * eff_sets - 1);
    end
    issue(c_op, c_line, c_set, c_slot);
  endtask

  initial begin
    int phase_ways [8] = '{8, 1, 0, 15, 3, 8, 1, 5};
    int phase_sets [8] = '{512, 1, 0, 1023, 7, 1, 512, 100};
    int idle_modes [4] = '{0, 84, 0, 33};
    for (int i = 0; i < 8; i++) line_pool[i] = $urandom;
    line_pool[0] = '0;
    line_pool[1] = '1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    set_geometry(8, 512);

    // directed: empty set, fill and replace, free twice, top edges
    issue(OP_LOOKUP, 32'h0, 0, 0);
    issue(OP_INSERT, 32'h0, 0, 0);
    issue(OP_INSERT, 32'hffff_ffff, 0, 1);
    issue(OP_LOOKUP, 32'h0, 0, 0);
    issue(OP_LOOKUP, 32'hffff_ffff, 0, 0);
    issue(OP_LIST, 32'h0, 0, 0);
    issue(OP_INSERT, 32'h5555_aaaa, 0, 0);
    issue(OP_INVAL, 32'h0, 0, 1);
    issue(OP_INVAL, 32'h0, 0, 1);
    issue(OP_INSERT, 32'ha5a5_5a5a, 0, 4095);
    issue(OP_LOOKUP, 32'ha5a5_5a5a, 511, 0);
    issue(OP_LIST, 32'h0, 511, 0);
    start <= 1'b0;
    drain();
    set_geometry(2, 4);
    issue(OP_LOOKUP, 32'h0, 4, 0);
    issue(OP_LIST, 32'h0, 511, 0);
    issue(OP_INSERT, 32'h1234_5678, 0, 8);
    issue(OP_INVAL, 32'h0, 0, 4095);
    issue(OP_LIST, 32'h0, 0, 0);
    issue(OP_INSERT, 32'h0000_0001, 0, 2);
    issue(OP_INSERT, 32'h8000_0000, 0, 3);
    issue(OP_LOOKUP, 32'h8000_0000, 1, 0);
    issue(OP_LIST, 32'h0, 3, 0);
    start <= 1'b0;
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct = idle_modes[p % 4];
      set_geometry(phase_ways[p], phase_sets[p]);
      for (int n = 0; n < 16; n++) random_command();
      start <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: set_associative_tag_array.f
+incdir+rtl
rtl/sat_pkg.sv
rtl/sat_front.sv
rtl/sat_queue.sv
rtl/sat_back.sv
rtl/set_associative_tag_array.sv
dv/set_associative_tag_array_checker.sv
dv/tb_set_associative_tag_array.sv
